// File: src/ddq_pkg.sv
// Shared operation codes, status codes, defaults and cell control type for the deque.
package ddq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 64;

	localparam int OP_W   = 3;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;
	localparam logic [OP_W-1:0] OP_REVERSE    = 3'd6;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// One update per cycle, broadcast to every cell; ends are physical ends.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cell_ctrl_t;

endpackage

// File: src/ddq_cell.sv
// One storage cell of the deque row: a word plus its occupied bit.
module ddq_cell
	import ddq_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_ctrl_t           ctrl,
	input  logic [WORD_BITS-1:0] push_value,
	input  logic [WORD_BITS-1:0] left_data,
	input  logic                 left_occ,
	input  logic [WORD_BITS-1:0] right_data,
	input  logic                 right_occ,
	output logic [WORD_BITS-1:0] data,
	output logic                 occ,
	output logic [WORD_BITS-1:0] back_data
);

	logic [WORD_BITS-1:0] data_q;
	logic                 occ_q;

	// Occupied bits form a thermometer: grow from the left, shrink from the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.push_front || ctrl.push_back) begin
			occ_q <= left_occ;
		end else if (ctrl.pop_front || ctrl.pop_back) begin
			occ_q <= right_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push_front) begin
			data_q <= left_data;
		end else if (ctrl.pop_front) begin
			data_q <= right_data;
		end else if (ctrl.push_back && !occ_q && left_occ) begin
			data_q <= push_value;
		end
	end

	assign data      = data_q;
	assign occ       = occ_q;
	// Only the last occupied cell drives the back word.
	assign back_data = (occ_q && !right_occ) ? data_q : '0;

endmodule

// File: src/double_ended_queue.sv
// Top level of the bounded double-ended queue built as a row of shifting cells.
// The queue is a row of DEPTH cells; cell 0 always holds the physical front and
// occupied cells form an unbroken run from cell 0. A push or pop at the physical
// front shifts the whole row by one place at once, a push at the
// physical back fills the first free cell, and a pop at the back only clears
// the last occupied bit. Reverse toggles a flag that swaps which physical end is
// the logical front, so it moves no entry at any occupancy. Each operation word
// is taken and its result appears from the output register on the
// next cycle; one word per cycle is sustained while the output does not stall.
// The input stalls only while a finished result is held by a stall
// on the output. Storage cells are not cleared at reset; only occupied cells are
// ever read, so no clearing pass is needed.
module double_ended_queue
	import ddq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int CNT_W    = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [OP_W-1:0]      operation,
	input  logic [WORD_BITS-1:0] push_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_BITS-1:0] data_out,
	output logic [CNT_W-1:0]     occupancy,
	output logic                 is_empty,
	output logic [STAT_W-1:0]    status
);

	logic                 in_fire;
	logic                 rev_q;
	logic [CNT_W-1:0]     count_q;
	logic                 empty_now;
	logic                 full_now;
	logic                 at_phys_front;
	cell_ctrl_t           ctrl;
	logic [CNT_W-1:0]     count_next;
	logic [WORD_BITS-1:0] data_next;
	logic [STAT_W-1:0]    status_next;
	logic [WORD_BITS-1:0] back_word;

	logic [WORD_BITS-1:0] cell_data [DEPTH];
	logic [WORD_BITS-1:0] cell_back [DEPTH];
	logic [DEPTH-1:0]     cell_occ;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] data_out_q;
	logic [CNT_W-1:0]     occupancy_q;
	logic                 is_empty_q;
	logic [STAT_W-1:0]    status_q;

	// Hold the input while an unread result sits in the output register.
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;

	assign empty_now = (count_q == '0);
	assign full_now  = (count_q == CNT_W'(DEPTH));

	// Front-type operations hit the physical front unless the order is reversed.
	assign at_phys_front = ((operation == OP_PUSH_FRONT) || (operation == OP_POP_FRONT) ||
		(operation == OP_READ_FRONT)) ^ rev_q;

	// Back word: the single last occupied cell drives it, all others give zero.
	always_comb begin
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_word = back_word | cell_back[i];
		end
	end

	always_comb begin
		ctrl        = '0;
		count_next  = count_q;
		data_next   = '0;
		status_next = ST_OK;
		case (operation)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full_now) begin
					status_next = ST_FULL;
				end else begin
					ctrl.push_front = in_fire && at_phys_front;
					ctrl.push_back  = in_fire && !at_phys_front;
					count_next      = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (empty_now) begin
					status_next = ST_EMPTY;
				end else begin
					ctrl.pop_front = in_fire && at_phys_front;
					ctrl.pop_back  = in_fire && !at_phys_front;
					count_next     = count_q - CNT_W'(1);
					data_next      = at_phys_front ? cell_data[0] : back_word;
				end
			end
			OP_READ_FRONT, OP_READ_BACK: begin
				if (empty_now) begin
					status_next = ST_EMPTY;
				end else begin
					data_next = at_phys_front ? cell_data[0] : back_word;
				end
			end
			default: begin
				// Reverse and the unused code change no stored entry.
			end
		endcase
	end

	// The cell row: each cell takes from its left or right neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_data;
		logic                 left_occ;
		logic [WORD_BITS-1:0] right_data;
		logic                 right_occ;

		if (i == 0) begin : g_first
			assign left_data = push_value;
			assign left_occ  = 1'b1;
		end else begin : g_inner_l
			assign left_data = cell_data[i-1];
			assign left_occ  = cell_occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
			assign right_occ  = 1'b0;
		end else begin : g_inner_r
			assign right_data = cell_data[i+1];
			assign right_occ  = cell_occ[i+1];
		end

		ddq_cell #(
			.WORD_BITS(WORD_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.push_value (push_value),
			.left_data  (left_data),
			.left_occ   (left_occ),
			.right_data (right_data),
			.right_occ  (right_occ),
			.data       (cell_data[i]),
			.occ        (cell_occ[i]),
			.back_data  (cell_back[i])
		);
	end

	// Update the count on every accepted word; toggle the direction flag on reverse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (in_fire) begin
			count_q <= count_next;
			if (operation == OP_REVERSE) begin
				rev_q <= !rev_q;
			end
		end
	end

	// Output register: load on accept, drop once taken downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_out_q  <= data_next;
			occupancy_q <= count_next;
			is_empty_q  <= (count_next == '0);
			status_q    <= status_next;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign occupancy = occupancy_q;
	assign is_empty  = is_empty_q;
	assign status    = status_q;

	a_occ_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_occ) == int'(count_q))
		else $error("occupied cells disagree with entry count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_FULL) |-> (occupancy_q == CNT_W'(DEPTH)))
		else $error("full refusal reported below depth");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_EMPTY) |-> is_empty_q && (data_out_q == '0))
		else $error("empty refusal with data or entries");

	a_reverse_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (operation == OP_REVERSE) |=> (rev_q != $past(rev_q)))
		else $error("reverse did not toggle direction");

endmodule
